// ===== sv/bpk_pkg.sv =====
// Bit packer package: word types, field widths and operation codes.
// No dependencies; imported by every module of the bit packer.
`timescale 1ns / 1ps
`default_nettype none

package bpk_pkg;

    localparam int CODE_W            = 32;
    localparam int LEN_IN_W          = 6;
    localparam int BYTE_W            = 8;
    localparam int PEND_W            = 7;
    localparam int CNT_W             = 3;
    localparam int MAX_CODE_BITS_DEF = 32;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 operation;
        logic [CODE_W-1:0]   code;
        logic [LEN_IN_W-1:0] length;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_word;

endpackage

`default_nettype wire

// ===== sv/bpk_front.sv =====
// Bit packer front end: holds the pending bits, merges each input word
// and hands completed bytes to the queue. Depends on bpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpk_front #(
    parameter int MAX_CODE_BITS = 32,
    parameter int DATA_W        = 32,
    parameter int NBC_W         = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  bpk_pkg::t_in_word     i_word,
    input  wire                   i_full,
    output logic                  o_push,
    output logic [DATA_W-1:0]     o_data,
    output logic [NBC_W-1:0]      o_nbytes
);
    import bpk_pkg::*;

    localparam int ACC_W = MAX_CODE_BITS + PEND_W;
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int TOT_W = $clog2(ACC_W + 1);

    logic [PEND_W-1:0] r_pend, n_pend;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              accept;
    logic [LEN_W-1:0]  len_eff;
    logic [ACC_W-1:0]  code_m;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  emitted;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  rem;
    logic [BYTE_W-1:0] flush_byte;

    assign accept = i_valid && !i_full;

    always_comb begin
        if (i_word.length > LEN_IN_W'(MAX_CODE_BITS)) begin
            len_eff = LEN_W'(MAX_CODE_BITS);
        end else begin
            len_eff = LEN_W'(i_word.length);
        end
        code_m     = ACC_W'(i_word.code) & ~({ACC_W{1'b1}} << len_eff);
        acc        = (ACC_W'(r_pend) << len_eff) | code_m;
        total      = TOT_W'(r_cnt) + TOT_W'(len_eff);
        rem        = total[CNT_W-1:0];
        emitted    = acc >> rem;
        flush_byte = BYTE_W'({1'b0, r_pend} << (4'd8 - {1'b0, r_cnt}));

        n_pend   = r_pend;
        n_cnt    = r_cnt;
        o_push   = 1'b0;
        o_data   = emitted[DATA_W-1:0];
        o_nbytes = NBC_W'(total >> CNT_W);
        if (accept) begin
            case (i_word.operation)
                OP_FLUSH: begin
                    o_push   = (r_cnt != '0);
                    o_data   = DATA_W'(flush_byte);
                    o_nbytes = NBC_W'(1);
                    n_pend   = '0;
                    n_cnt    = '0;
                end
                OP_WRITE: begin
                    o_push = (total >> CNT_W) != '0;
                    n_cnt  = rem;
                    n_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bpk_queue.sv =====
// Bit packer job queue: two-entry register FIFO between front and back.
// Depends on bpk_pkg for shared conventions only.
`timescale 1ns / 1ps
`default_nettype none

module bpk_queue #(
    parameter int ENTRY_W = 35
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire [ENTRY_W-1:0]  i_entry,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_valid,
    output logic [ENTRY_W-1:0] o_entry
);
    import bpk_pkg::*;

    logic [ENTRY_W-1:0] r_mem [2];
    logic               r_wr, r_rd;
    logic [1:0]         r_fill;
    logic               do_push, do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_fill <= r_fill + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

// ===== sv/bpk_back.sv =====
// Bit packer back end: takes queued jobs and sends their bytes one per
// cycle through the output register while the output is not stalled. Depends on bpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpk_back #(
    parameter int NB    = 4,
    parameter int NBC_W = 3
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_q_valid,
    input  wire [NB*8+NBC_W-1:0]      i_q_entry,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire                       i_stall,
    output bpk_pkg::t_out_word        o_word
);
    import bpk_pkg::*;

    localparam int DATA_W = NB * BYTE_W;
    localparam int IDX_W  = (NB > 1) ? $clog2(NB) : 1;

    logic [DATA_W-1:0] r_data;
    logic [IDX_W-1:0]  r_idx;
    logic              r_busy;
    logic              r_ov;
    t_out_word         r_out;
    logic              adv;
    logic [NBC_W-1:0]  q_nb;

    assign adv     = !r_ov || !i_stall;
    assign q_nb    = i_q_entry[NBC_W-1:0];
    assign o_pop   = i_q_valid && (!r_busy || (adv && r_idx == '0));
    assign o_valid = r_ov;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_entry[NBC_W +: DATA_W];
        end
        if (adv && r_busy) begin
            r_out.out_byte <= r_data[r_idx*BYTE_W +: BYTE_W];
            r_out.last     <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (adv) begin
                r_ov <= r_busy;
                if (r_busy && r_idx != '0) begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= IDX_W'(q_nb - NBC_W'(1));
            end else if (adv && r_busy && r_idx == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/msb_first_bit_packer_core.sv =====
// MSB-first bit packer top level: front end, job queue and byte back end.
// Depends on bpk_pkg, bpk_front, bpk_queue, bpk_back.
//
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_stall    | t_in_word  (operation, code, length)
//  out     | output    | o_out_valid / i_out_stall  | t_out_word (out_byte, last)
//
// A write has the back end send each of its completed bytes in turn: up to
// (MAX_CODE_BITS + 7) / 8, four at the default. Flush: one byte or none.
// An accepted word's bytes pass through the queue, the back end's job register
// and its output register; the front takes a word each cycle while the two-entry queue has room.
// Synchronous reset clears pending bits, queue and output; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_packer_core #(
    parameter int MAX_CODE_BITS = bpk_pkg::MAX_CODE_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  bpk_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output bpk_pkg::t_out_word  o_out_word
);
    import bpk_pkg::*;

    localparam int NB      = (MAX_CODE_BITS + PEND_W) / BYTE_W;
    localparam int NBC_W   = $clog2(NB + 1);
    localparam int DATA_W  = NB * BYTE_W;
    localparam int ENTRY_W = DATA_W + NBC_W;

    logic               push, full, pop, q_valid;
    logic [DATA_W-1:0]  push_data;
    logic [NBC_W-1:0]   push_nb;
    logic [ENTRY_W-1:0] q_entry;

    assign o_in_stall = full;

    bpk_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DATA_W        (DATA_W),
        .NBC_W         (NBC_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .i_full   (full),
        .o_push   (push),
        .o_data   (push_data),
        .o_nbytes (push_nb)
    );

    bpk_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry ({push_data, push_nb}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    bpk_back #(
        .NB    (NB),
        .NBC_W (NBC_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_word    (o_out_word)
    );

endmodule

`default_nettype wire

// ===== sv/bpk_checker.sv =====
// Port-level checker for the bit packer and its bind to the top level.
// Depends on bpk_pkg and msb_first_bit_packer_core.
`timescale 1ns / 1ps
`default_nettype none

module bpk_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input bpk_pkg::t_out_word o_out_word
);
    import bpk_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed under stall");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind msb_first_bit_packer_core bpk_checker u_bpk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
